// ----- src/scmi_pkg.sv -----
`timescale 1ns / 1ps
package scmi_pkg;
  localparam int VAL_W = 17;
  localparam int COL_W = 24;
  localparam int CNT_W = 5;
  localparam int FRAC_W = 16;
  localparam int QUO_W = 19;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_WR_POS = 2'd1,
    OP_WR_NEG = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_ZERO_COLOR = 2'd0,
    CFG_POS_COUNT  = 2'd1,
    CFG_NEG_COUNT  = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_t;

  // Per-item control that rides down the divider and blend stages.
  typedef struct packed {
    logic                 fixed;   // colour is final, no blending
    logic [COL_W-1:0]     c0;
    logic [COL_W-1:0]     c1;
  } blend_ctl_t;
endpackage

// ----- src/signed_colormap_interpolator_core.sv -----
`timescale 1ns / 1ps
// Pipeline: 2 search stages, 34 divider stages (one quotient bit each) and
// 2 blend stages, then the output register. One transaction per cycle unless
// the output stalls; all stages move together. Reset (rst_n low, synchronous)
// clears valid bits and the zero colour and sets both point counts to 2; the
// point tables are not cleared and must be written before they are read.
module signed_colormap_interpolator_core #(
  parameter int MAX_POINTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [3:0]  in_point_index,
  input  logic signed [16:0] in_value,
  input  logic [7:0]  in_point_red,
  input  logic [7:0]  in_point_green,
  input  logic [7:0]  in_point_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import scmi_pkg::*;

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  // The pipeline moves when the output register is empty or being drained.
  logic en;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  logic [COL_W-1:0] zero_color_r;
  logic [CNT_W-1:0] pos_cnt_r, neg_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_color_r <= '0;
      pos_cnt_r    <= CNT_W'(2);
      neg_cnt_r    <= CNT_W'(2);
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ZERO_COLOR: zero_color_r <= cfg_data;
        CFG_POS_COUNT:  pos_cnt_r    <= cfg_data[CNT_W-1:0];
        CFG_NEG_COUNT:  neg_cnt_r    <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Control-point tables, held as registers so every point can be compared
  // against the scalar at once. Writes happen on acceptance of a write op.
  logic signed [VAL_W-1:0] ppos_r [MAX_POINTS];
  logic signed [VAL_W-1:0] npos_r [MAX_POINTS];
  logic [COL_W-1:0]        pcol_r [MAX_POINTS];
  logic [COL_W-1:0]        ncol_r [MAX_POINTS];

  logic acc;
  assign acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (acc && (32'(in_point_index) < MAX_POINTS)) begin
      if (op_t'(in_op) == OP_WR_POS) begin
        ppos_r[IW'(in_point_index)] <= in_value;
        pcol_r[IW'(in_point_index)] <= {in_point_red, in_point_green, in_point_blue};
      end else if (op_t'(in_op) == OP_WR_NEG) begin
        npos_r[IW'(in_point_index)] <= in_value;
        ncol_r[IW'(in_point_index)] <= {in_point_red, in_point_green, in_point_blue};
      end
    end
  end

  // Stage 1: pick the table, compare the scalar against every point, and
  // clamp the count. The flags move on with the scalar and the clamped count.
  logic                    s1_vld_r, s1_zero_r, s1_neg_r;
  logic signed [VAL_W-1:0] s1_val_r;
  logic [MAX_POINTS-1:0]   s1_le_r;
  logic [CW-1:0]           s1_n_r;

  logic [CW-1:0] n_nxt;
  logic [CNT_W-1:0] cnt_sel;
  always_comb begin
    cnt_sel = (in_value < 0) ? neg_cnt_r : pos_cnt_r;
    if (cnt_sel < CNT_W'(2))                 n_nxt = CW'(2);
    else if (32'(cnt_sel) > MAX_POINTS)      n_nxt = CW'(MAX_POINTS);
    else                                     n_nxt = CW'(cnt_sel);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= acc && (op_t'(in_op) == OP_LOOKUP);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_val_r  <= in_value;
      s1_zero_r <= (in_value == '0);
      s1_neg_r  <= (in_value < 0);
      s1_n_r    <= n_nxt;
      for (int k = 0; k < MAX_POINTS; k++) begin
        s1_le_r[k] <= (in_value < 0) ? (npos_r[k] <= in_value)
                                     : (ppos_r[k] <= in_value);
      end
    end
  end

  // Stage 2: find the segment, fetch its endpoints, set up the division.
  logic                    s2_vld_r;
  logic [VAL_W:0]          s2_num_r, s2_den_r;
  blend_ctl_t              s2_ctl_r;

  logic [IW-1:0]           seg;
  logic [IW-1:0]           last;
  logic signed [VAL_W-1:0] p0, p1, plast;
  logic [COL_W-1:0]        c0, c1, clast;
  blend_ctl_t              ctl_nxt;
  logic [VAL_W:0]          num_nxt, den_nxt;
  always_comb begin
    last = IW'(s1_n_r - CW'(1));
    seg  = '0;
    for (int k = 0; k < MAX_POINTS - 1; k++) begin
      if (s1_le_r[k] && (32'(k) + 2 <= 32'(s1_n_r))) seg = IW'(k);
    end
    if (s1_neg_r) begin
      p0 = npos_r[seg]; p1 = npos_r[IW'(seg + IW'(1))]; plast = npos_r[last];
      c0 = ncol_r[seg]; c1 = ncol_r[IW'(seg + IW'(1))]; clast = ncol_r[last];
    end else begin
      p0 = ppos_r[seg]; p1 = ppos_r[IW'(seg + IW'(1))]; plast = ppos_r[last];
      c0 = pcol_r[seg]; c1 = pcol_r[IW'(seg + IW'(1))]; clast = pcol_r[last];
    end
    num_nxt = (VAL_W+1)'({s1_val_r[VAL_W-1], s1_val_r} - {p0[VAL_W-1], p0});
    den_nxt = (VAL_W+1)'({p1[VAL_W-1], p1} - {p0[VAL_W-1], p0});
    ctl_nxt.c0    = c0;
    ctl_nxt.c1    = c1;
    ctl_nxt.fixed = 1'b0;
    if (s1_zero_r) begin
      ctl_nxt.fixed = 1'b1; ctl_nxt.c0 = zero_color_r;
    end else if (!s1_le_r[0]) begin
      ctl_nxt.fixed = 1'b1; ctl_nxt.c0 = s1_neg_r ? ncol_r[0] : pcol_r[0];
    end else if (plast <= s1_val_r) begin
      ctl_nxt.fixed = 1'b1; ctl_nxt.c0 = clast;
    end else if (!(p1 > p0)) begin
      // Span not positive: fraction zero, which is the first colour.
      ctl_nxt.fixed = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ctl_r <= ctl_nxt;
      s2_num_r <= ctl_nxt.fixed ? '0 : num_nxt;
      s2_den_r <= ctl_nxt.fixed ? (VAL_W+1)'(1) : den_nxt;
    end
  end

  logic             dv_vld;
  logic [FRAC_W-1:0] dv_frac;
  blend_ctl_t       dv_ctl;

  scmi_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s2_vld_r),
    .in_num   (s2_num_r),
    .in_den   (s2_den_r),
    .in_ctl   (s2_ctl_r),
    .out_vld  (dv_vld),
    .out_frac (dv_frac),
    .out_ctl  (dv_ctl)
  );

  logic             bl_vld;
  logic [COL_W-1:0] bl_color;

  scmi_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (dv_vld),
    .in_frac   (dv_frac),
    .in_ctl    (dv_ctl),
    .out_vld   (bl_vld),
    .out_color (bl_color)
  );

  // Output register; it holds while the downstream side stalls.
  logic             out_vld_r;
  logic [COL_W-1:0] out_col_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= bl_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_col_r <= bl_color;
    end
  end

  assign out_valid = out_vld_r;
  assign out_red   = out_col_r[23:16];
  assign out_green = out_col_r[15:8];
  assign out_blue  = out_col_r[7:0];
endmodule

// ----- src/scmi_divider.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider: quotient = floor(num * 2^16 / den), one
// quotient bit per stage. Each stage carries a side-band control word.
module scmi_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [scmi_pkg::VAL_W:0]    in_num,
  input  logic [scmi_pkg::VAL_W:0]    in_den,
  input  scmi_pkg::blend_ctl_t        in_ctl,
  output logic                        out_vld,
  output logic [scmi_pkg::FRAC_W-1:0] out_frac,
  output scmi_pkg::blend_ctl_t        out_ctl
);
  import scmi_pkg::*;

  localparam int STG = VAL_W + 1 + FRAC_W;  // dividend bits
  localparam int RW  = VAL_W + 2;

  logic [STG-1:0] vld_r;
  logic [RW-1:0]  rem_r  [STG];
  logic [STG-1:0] dvd_r  [STG];
  logic [VAL_W:0] den_r  [STG];
  logic [QUO_W-1:0] q_r  [STG];
  blend_ctl_t     ctl_r  [STG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[STG-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < STG; s++) begin
        logic [RW-1:0]    rin;
        logic [STG-1:0]   din;
        logic [VAL_W:0]   dn;
        logic [QUO_W-1:0] qin;
        logic [RW-1:0]    sh;
        logic [RW-1:0]    df;
        if (s == 0) begin
          rin = '0;
          din = {in_num, {FRAC_W{1'b0}}};
          dn  = in_den;
          qin = '0;
          ctl_r[s] <= in_ctl;
        end else begin
          rin = rem_r[s-1];
          din = dvd_r[s-1];
          dn  = den_r[s-1];
          qin = q_r[s-1];
          ctl_r[s] <= ctl_r[s-1];
        end
        sh = {rin[RW-2:0], din[STG-1]};
        df = sh - {1'b0, dn};
        if (!df[RW-1]) begin
          rem_r[s] <= df;
          q_r[s]   <= {qin[QUO_W-2:0], 1'b1};
        end else begin
          rem_r[s] <= sh;
          q_r[s]   <= {qin[QUO_W-2:0], 1'b0};
        end
        dvd_r[s] <= {din[STG-2:0], 1'b0};
        den_r[s] <= dn;
      end
    end
  end

  assign out_vld  = vld_r[STG-1];
  assign out_ctl  = ctl_r[STG-1];
  // With num < den it fits 16 bits; larger quotients saturate.
  assign out_frac = (q_r[STG-1] > QUO_W'(16'hFFFF)) ? 16'hFFFF
                                                    : q_r[STG-1][FRAC_W-1:0];
endmodule

// ----- src/scmi_blend.sv -----
`timescale 1ns / 1ps
// Two-stage channel blend: products registered, then sum, round and clamp.
module scmi_blend (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [scmi_pkg::FRAC_W-1:0]   in_frac,
  input  scmi_pkg::blend_ctl_t          in_ctl,
  output logic                          out_vld,
  output logic [scmi_pkg::COL_W-1:0]    out_color
);
  import scmi_pkg::*;

  logic [1:0]  vld_r;
  logic [23:0] p0_r [3];
  logic [23:0] p1_r [3];
  logic        fixed_r;
  logic [COL_W-1:0] fcol_r;
  logic [COL_W-1:0] col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fixed_r <= in_ctl.fixed;
      fcol_r  <= in_ctl.c0;
      for (int k = 0; k < 3; k++) begin
        p0_r[k] <= 24'(in_ctl.c0[8*k +: 8]) * 24'(17'h10000 - {1'b0, in_frac});
        p1_r[k] <= 24'(in_ctl.c1[8*k +: 8]) * 24'(in_frac);
      end
      if (fixed_r) begin
        col_r <= fcol_r;
      end else begin
        for (int k = 0; k < 3; k++) begin
          logic [25:0] sm;
          sm = {2'b0, p0_r[k]} + {2'b0, p1_r[k]} + 26'h8000;
          col_r[8*k +: 8] <= (sm[25:16] > 10'd255) ? 8'hFF : sm[23:16];
        end
      end
    end
  end

  assign out_vld   = vld_r[1];
  assign out_color = col_r;
endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import scmi_pkg::*;

  // Shadow copy of the color map. It keeps the point tables, the zero color
  // and the two point counts, and predicts the color for every lookup.
  class colormap_scoreboard;
    logic signed [VAL_W-1:0] point_pos[2][16];
    logic [COL_W-1:0]        point_col[2][16];
    logic [COL_W-1:0]        zero_color;
    logic [CNT_W-1:0]        point_count[2];
    logic [COL_W-1:0]        expected_colors[$];
    int                      errors;

    function void reset_state();
      zero_color     = '0;
      point_count[0] = 2;
      point_count[1] = 2;
      errors         = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [23:0] data);
      case (idx)
        CFG_ZERO_COLOR: zero_color = data;
        CFG_POS_COUNT:  point_count[0] = data[CNT_W-1:0];
        CFG_NEG_COUNT:  point_count[1] = data[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    // Side 0 is the positive table and side 1 the negative table.
    function logic [COL_W-1:0] blend_color(int side, logic signed [VAL_W-1:0] v);
      int n;
      int seg;
      longint frac;
      longint span;
      longint c0;
      longint c1;
      longint ch;
      logic [COL_W-1:0] color;
      n = (point_count[side] < 2) ? 2 : (point_count[side] > 16) ? 16 : point_count[side];
      if (v < point_pos[side][0]) return point_col[side][0];
      if (v >= point_pos[side][n-1]) return point_col[side][n-1];
      seg = 0;
      for (int k = 0; k <= n - 2; k++)
        if (point_pos[side][k] <= v) seg = k;
      span = longint'(point_pos[side][seg+1]) - longint'(point_pos[side][seg]);
      if (span > 0 && v >= point_pos[side][seg]) begin
        frac = ((longint'(v) - longint'(point_pos[side][seg])) <<< 16) / span;
        if (frac > 65535) frac = 65535;
      end else begin
        frac = 0;
      end
      for (int k = 0; k < 3; k++) begin
        c0 = (point_col[side][seg] >> (16 - 8 * k)) & 8'hff;
        c1 = (point_col[side][seg+1] >> (16 - 8 * k)) & 8'hff;
        ch = (c0 * (65536 - frac) + c1 * frac + 32768) >>> 16;
        if (ch > 255) ch = 255;
        color[16 - 8 * k +: 8] = ch[7:0];
      end
      return color;
    endfunction

    function void note_input(op_t op, logic [3:0] idx, logic signed [VAL_W-1:0] v,
                             logic [7:0] r, logic [7:0] g, logic [7:0] b);
      case (op)
        OP_WR_POS, OP_WR_NEG: begin
          point_pos[op == OP_WR_NEG][idx] = v;
          point_col[op == OP_WR_NEG][idx] = {r, g, b};
        end
        OP_LOOKUP: begin
          if (v > 0)
            expected_colors.insert(expected_colors.size(), blend_color(0, v));
          else if (v < 0)
            expected_colors.insert(expected_colors.size(), blend_color(1, v));
          else
            expected_colors.insert(expected_colors.size(), zero_color);
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      logic [COL_W-1:0] want;
      if (expected_colors.size() == 0) begin
        report($sformatf("unexpected color %02x%02x%02x", r, g, b));
        return;
      end
      want = expected_colors.pop_front();
      if (r !== want[23:16]) report($sformatf("red %02x, expected %02x", r, want[23:16]));
      if (g !== want[15:8]) report($sformatf("green %02x, expected %02x", g, want[15:8]));
      if (b !== want[7:0]) report($sformatf("blue %02x, expected %02x", b, want[7:0]));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_op = OP_NONE;
  logic [3:0]  in_point_index = '0;
  logic signed [16:0] in_value = '0;
  logic [7:0]  in_point_red = '0;
  logic [7:0]  in_point_green = '0;
  logic [7:0]  in_point_blue = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_ZERO_COLOR;
  logic [23:0] cfg_data = '0;

  // When set, neither side idles, so the pipeline runs at full rate.
  bit calm = 1'b0;
  colormap_scoreboard sb = new();

  signed_colormap_interpolator_core u_dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // The sink stalls with a chance of about 27 percent unless calm is set.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 27);
  end

  // Both monitors sample at the clock edge, before any driver update lands, so
  // each accepted transaction is seen with exactly the values the block saw.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_input(op_t'(in_op), in_point_index, in_value,
                    in_point_red, in_point_green, in_point_blue);
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_red, out_green, out_blue);
  end

  // Sends one transaction. A random gap may precede it; valid is only lowered
  // inside such a gap, so back-to-back items keep valid high across edges.
  task send(op_t op, logic [3:0] idx, logic signed [16:0] v, logic [23:0] color);
    while (!calm && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_point_index <= idx;
    in_value       <= v;
    in_point_red   <= color[23:16];
    in_point_green <= color[15:8];
    in_point_blue  <= color[7:0];
    do @(posedge clk); while (!in_ready);
  endtask

  // Waits for every expected color, then lets the pipeline run empty; table
  // writes need no wait, as they take effect on acceptance.
  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_colors.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  // Valid drops for one cycle after each write, so consecutive writes never
  // drive it twice in the same step.
  task cfg_write(cfg_idx_t idx, logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Rewrites all 16 slots of one table so that no lookup ever touches an
  // unwritten entry. Sorted tables are the normal case; an unsorted table
  // exercises the search when positions are out of order.
  task load_table(op_t op, bit sorted);
    int spot[16];
    foreach (spot[k])
      spot[k] = (op == OP_WR_POS) ? int'($urandom_range(65535, 1))
                                  : -int'($urandom_range(65536, 1));
    if (sorted) spot.sort();
    foreach (spot[k]) send(op, k[3:0], spot[k][16:0], 24'($urandom()));
  endtask

  // Picks a lookup scalar: often right at or near a control point, otherwise
  // anywhere in the full signed range, with the extremes and zero mixed in.
  function logic signed [16:0] pick_scalar();
    int side;
    int sel;
    sel = $urandom_range(99);
    side = $urandom_range(1);
    if (sel < 45)
      return sb.point_pos[side][$urandom_range(15)] + $signed(17'($urandom_range(6))) - 17'sd3;
    if (sel < 50)
      return 17'sd0;
    if (sel < 55)
      return $urandom_range(1) ? 17'sh0ffff : 17'sh10000;
    return 17'($urandom());
  endfunction

  task random_items(int total);
    int pick;
    for (int k = 0; k < total; k++) begin
      pick = $urandom_range(99);
      if (pick < 85)
        send(OP_LOOKUP, 4'($urandom()), pick_scalar(), 24'($urandom()));
      else if (pick < 91)
        send(OP_WR_POS, 4'($urandom()), 17'($urandom_range(65535, 1)), 24'($urandom()));
      else if (pick < 97)
        send(OP_WR_NEG, 4'($urandom()), 17'(-int'($urandom_range(65536, 1))),
             24'($urandom()));
      else
        send(OP_NONE, 4'($urandom()), 17'($urandom()), 24'($urandom()));
    end
  endtask

  initial begin
    logic [23:0] zero_setting[6];
    logic [4:0]  pos_setting[6];
    logic [4:0]  neg_setting[6];

    zero_setting = '{24'hffffff, 24'h000000, 24'ha5c35a, 24'h5a3ca5, 24'h123456, 24'h0f0f0f};
    pos_setting  = '{5'd16, 5'd0, 5'd2, 5'd31, 5'd9, 5'd17};
    neg_setting  = '{5'd16, 5'd31, 5'd17, 5'd1, 5'd2, 5'd5};

    sb.reset_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: evenly spread tables, then zero, the smallest and largest
    // scalars of each sign, a scalar right on a point, and the unused op. The
    // reset counts of two points apply here.
    for (int k = 0; k < 16; k++)
      send(OP_WR_POS, k[3:0], 17'(1 + k * 4368), 24'($urandom()));
    for (int k = 0; k < 16; k++)
      send(OP_WR_NEG, k[3:0], 17'(-65536 + k * 4096), 24'($urandom()));
    send(OP_LOOKUP, 4'd0, 17'sd0, 24'h0);
    send(OP_LOOKUP, 4'd0, 17'sd1, 24'h0);
    send(OP_LOOKUP, 4'd0, -17'sd1, 24'h0);
    send(OP_LOOKUP, 4'd0, 17'sh0ffff, 24'h0);
    send(OP_LOOKUP, 4'd0, 17'sh10000, 24'h0);
    send(OP_LOOKUP, 4'd0, 17'sd2185, 24'h0);
    send(OP_LOOKUP, 4'd0, 17'sd4369, 24'h0);
    send(OP_LOOKUP, 4'd0, -17'sd61440, 24'h0);
    send(OP_LOOKUP, 4'd0, -17'sd63000, 24'h0);
    send(OP_NONE, 4'hf, 17'sh1ffff, 24'hffffff);
    send(OP_LOOKUP, 4'd0, 17'sd0, 24'h0);
    drain();

    // Each phase changes every register while idle, reloads the tables, and
    // runs random traffic. Phase two runs with no idling on either side.
    for (int ph = 0; ph < 6; ph++) begin
      cfg_write(CFG_ZERO_COLOR, zero_setting[ph]);
      cfg_write(CFG_POS_COUNT, {19'($urandom()), pos_setting[ph]});
      cfg_write(CFG_NEG_COUNT, {19'($urandom()), neg_setting[ph]});
      calm = (ph == 2);
      load_table(OP_WR_POS, ph != 4);
      load_table(OP_WR_NEG, ph != 4);
      random_items(265);
      drain();
    end
    calm = 1'b0;

    if (sb.errors == 0 && sb.expected_colors.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ----- sim.f -----
src/scmi_pkg.sv
src/scmi_divider.sv
src/scmi_blend.sv
src/signed_colormap_interpolator_core.sv
tb/tb.sv
